### rtl/core/pcmx_pkg.sv
`default_nettype none
package pcmx_pkg;

    localparam int STEP_W   = 18;
    localparam int POS_W    = 20;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = 7;
    localparam int AGE_W    = 32;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PLAY = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // ceil-biased reciprocal of 127 over 2^21, exact for magnitudes up to 16256
    localparam logic [14:0] DIV127_RECIP = 15'd16514;
    localparam int          DIV127_SHIFT = 21;

    typedef logic [STEP_W-1:0] step_rom_t [256];

    // 2.16 step of 2^((pitch-128)/64), rounded down
    function automatic step_rom_t build_step_rom();
        step_rom_t rom;
        real       r;
        for (int p = 0; p < 256; p++) begin
            r = 65536.0 * (2.0 ** ((p - 128) / 64.0));
            rom[p] = STEP_W'($rtoi(r));
        end
        return rom;
    endfunction

    localparam step_rom_t STEP_ROM = build_step_rom();

endpackage
`default_nettype wire

### rtl/core/pcmx_addr_mod.sv
`default_nettype none
module pcmx_addr_mod #(
    parameter int DEPTH = 262144
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [19:0]              value,
    output logic                          done,
    output logic [$clog2(DEPTH)-1:0]      addr
);
    import pcmx_pkg::*;

    localparam int unsigned RECIP = 32'd1073741824 / DEPTH;  // 2^30 / DEPTH
    localparam int          AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_EST  = 4'b0010,
        M_MUL  = 4'b0100,
        M_FIX  = 4'b1000
    } mod_state_t;

    mod_state_t  state_reg, state_next;
    logic [19:0] val_reg;
    logic [9:0]  q_reg;
    logic [19:0] rem_reg;
    logic [30:0] est_prod;
    logic [28:0] qd_prod;

    // quotient estimate from the top ten bits falls short by at most two
    assign est_prod = {1'b0, val_reg[19:10]} * 21'(RECIP);
    assign qd_prod  = q_reg * 19'(DEPTH);
    assign done     = (state_reg == M_FIX) && (rem_reg < 20'(DEPTH));
    assign addr     = rem_reg[AW-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:  if (start) state_next = M_EST;
            M_EST:   state_next = M_MUL;
            M_MUL:   state_next = M_FIX;
            M_FIX:   if (rem_reg < 20'(DEPTH)) state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            M_IDLE: if (start) val_reg <= value;
            M_EST:  q_reg <= est_prod[29:20];
            M_MUL:  rem_reg <= val_reg - qd_prod[19:0];
            M_FIX:  if (rem_reg >= 20'(DEPTH)) rem_reg <= rem_reg - 20'(DEPTH);
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/pitched_pcm_voice_mixer.sv
`default_nettype none
// Voice mixer over an internal byte-wide sample memory. One item is taken at a
// time; s_ready is high only while the sequencer is idle. A load waits on the
// address-wrap unit. A play scans one voice per cycle for a slot; for an
// exclusive sound it first scans for a voice that plays the same sound.
// A tick visits each voice in turn and then waits for the previous result
// to leave before it hands out its own: each
// active voice runs the shared address-wrap unit, one memory read, one
// multiply and one divide-by-127 step before the next voice. No clearing pass
// is run; the sample memory must be loaded before it is played.
module pitched_pcm_voice_mixer #(
    parameter int VOICES           = 8,
    parameter int SOUND_COUNT      = 128,
    parameter int SAMPLE_MEM_DEPTH = 262144
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [17:0] s_mem_addr,
    input  wire logic [7:0]  s_mem_byte,
    input  wire logic [7:0]  s_sound_id,
    input  wire logic        s_exclusive,
    input  wire logic [17:0] s_start_addr,
    input  wire logic [18:0] s_sample_count,
    input  wire logic [7:0]  s_volume,
    input  wire logic [7:0]  s_pitch,
    input  wire logic [7:0]  s_separation,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_mixed_sample
);
    import pcmx_pkg::*;

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW    = $clog2(SAMPLE_MEM_DEPTH);
    localparam int ACC_W = VW + 9;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b00000000001,
        S_LOAD_WAIT  = 11'b00000000010,
        S_PLAY_EXCL  = 11'b00000000100,
        S_PLAY_FIND  = 11'b00000001000,
        S_PLAY_GAIN1 = 11'b00000010000,
        S_PLAY_GAIN2 = 11'b00000100000,
        S_TICK_SEL   = 11'b00001000000,
        S_TICK_WAIT  = 11'b00010000000,
        S_TICK_MUL   = 11'b00100000000,
        S_TICK_ACC   = 11'b01000000000,
        S_TICK_OUT   = 11'b10000000000
    } mix_state_t;

    mix_state_t state_reg, state_next;

    // captured item
    logic [7:0]  byte_reg, sound_reg, volume_reg, pitch_reg, sep_reg;
    logic [17:0] start_reg;
    logic [18:0] count_reg;

    // voice state
    logic [VOICES-1:0] active_reg;
    logic [POS_W-1:0]  pos_reg   [VOICES];
    logic [POS_W-1:0]  end_reg   [VOICES];
    logic [FRAC_W-1:0] frac_reg  [VOICES];
    logic [STEP_W-1:0] step_reg  [VOICES];
    logic [7:0]        snd_reg   [VOICES];
    logic [GAIN_W-1:0] gain_reg  [VOICES];
    logic [AGE_W-1:0]  age_reg   [VOICES];
    logic [AGE_W-1:0]  counter_reg;

    logic [VW-1:0]     vidx_reg;
    logic [VW-1:0]     slot_reg;
    logic [AGE_W-1:0]  oldest_reg;
    logic [14:0]       sq_reg;
    logic signed [15:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [7:0]        rd_reg;
    logic              m_valid_reg;
    logic [7:0]        m_sample_reg;

    logic [7:0] mem [SAMPLE_MEM_DEPTH];

    // shared address wrap unit
    logic          mod_start, mod_done;
    logic [19:0]   mod_value;
    logic [AW-1:0] mod_addr;

    pcmx_addr_mod #(
        .DEPTH (SAMPLE_MEM_DEPTH)
    ) u_addr_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (mod_value),
        .done    (mod_done),
        .addr    (mod_addr)
    );

    logic s_fire, last_voice, snd_ok, out_free;
    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign last_voice = (vidx_reg == VW'(VOICES - 1));
    assign snd_ok     = (s_sound_id != 8'd0) && ({1'b0, s_sound_id} < 9'(SOUND_COUNT));
    assign out_free   = !m_valid_reg || m_ready;

    assign mod_start = (s_fire && (s_kind == KIND_LOAD)) ||
                       ((state_reg == S_TICK_SEL) && active_reg[vidx_reg]);
    assign mod_value = (state_reg == S_IDLE) ? {2'b00, s_mem_addr} : pos_reg[vidx_reg];

    // gain and advance arithmetic
    logic signed [9:0]  sep_s;
    logic signed [19:0] sep_sq;
    logic [22:0]        att_prod;
    logic [8:0]         gain_diff;
    logic [GAIN_W-1:0]  gain_new;
    logic signed [8:0]  smp_c;
    logic [18:0]        frac_sum;
    logic [POS_W-1:0]   pos_adv;
    logic [15:0]        mag;
    logic [28:0]        div_prod;
    logic signed [8:0]  term;

    assign sep_s     = $signed({2'b00, sep_reg}) - 10'sd128;
    assign sep_sq    = sep_s * sep_s;
    assign att_prod  = volume_reg * sq_reg;
    assign gain_diff = {1'b0, volume_reg} - {2'b00, att_prod[22:16]};
    assign gain_new  = (gain_diff > 9'd127) ? 7'd127 : gain_diff[6:0];

    assign smp_c    = $signed({1'b0, rd_reg}) - 9'sd128;
    assign frac_sum = {3'b000, frac_reg[vidx_reg]} + {1'b0, step_reg[vidx_reg]};
    assign pos_adv  = pos_reg[vidx_reg] + POS_W'(frac_sum[18:16]);

    assign mag      = prod_reg[15] ? 16'(-prod_reg) : 16'(prod_reg);
    assign div_prod = mag[13:0] * DIV127_RECIP;
    assign term     = prod_reg[15] ? -$signed({1'b0, div_prod[28:DIV127_SHIFT]})
                                   :  $signed({1'b0, div_prod[28:DIV127_SHIFT]});

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_kind)
                        KIND_LOAD: state_next = S_LOAD_WAIT;
                        KIND_PLAY: if (snd_ok) state_next = s_exclusive ? S_PLAY_EXCL
                                                                      : S_PLAY_FIND;
                        KIND_TICK: state_next = S_TICK_SEL;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD_WAIT: if (mod_done) state_next = S_IDLE;
            S_PLAY_EXCL: begin
                if ((active_reg[vidx_reg] && snd_reg[vidx_reg] == sound_reg) || last_voice)
                    state_next = S_PLAY_FIND;
            end
            S_PLAY_FIND: if (!active_reg[vidx_reg] || last_voice) state_next = S_PLAY_GAIN1;
            S_PLAY_GAIN1: state_next = S_PLAY_GAIN2;
            S_PLAY_GAIN2: state_next = S_IDLE;
            S_TICK_SEL: begin
                if (active_reg[vidx_reg]) state_next = S_TICK_WAIT;
                else if (last_voice)      state_next = S_TICK_OUT;
            end
            S_TICK_WAIT: if (mod_done) state_next = S_TICK_MUL;
            S_TICK_MUL:  state_next = S_TICK_ACC;
            S_TICK_ACC:  state_next = last_voice ? S_TICK_OUT : S_TICK_SEL;
            S_TICK_OUT:  if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_TICK_OUT) && out_free) m_valid_reg <= 1'b1;
            else if (m_ready)                         m_valid_reg <= 1'b0;
            case (state_reg)
                S_PLAY_EXCL: begin
                    if (active_reg[vidx_reg] && snd_reg[vidx_reg] == sound_reg)
                        active_reg[vidx_reg] <= 1'b0;
                end
                S_PLAY_GAIN2: begin
                    active_reg[slot_reg] <= 1'b1;
                    counter_reg          <= counter_reg + 1'b1;
                end
                S_TICK_MUL: begin
                    if (pos_adv >= end_reg[vidx_reg]) active_reg[vidx_reg] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            byte_reg   <= s_mem_byte;
            sound_reg  <= s_sound_id;
            volume_reg <= s_volume;
            pitch_reg  <= s_pitch;
            sep_reg    <= s_separation;
            start_reg  <= s_start_addr;
            count_reg  <= s_sample_count;
            vidx_reg   <= '0;
            slot_reg   <= '0;
            oldest_reg <= counter_reg;
            acc_reg    <= '0;
        end
        case (state_reg)
            S_PLAY_EXCL: begin
                if ((active_reg[vidx_reg] && snd_reg[vidx_reg] == sound_reg) || last_voice)
                    vidx_reg <= '0;
                else
                    vidx_reg <= vidx_reg + 1'b1;
            end
            S_PLAY_FIND: begin
                // first free voice wins, else the oldest active one
                if (!active_reg[vidx_reg]) begin
                    slot_reg <= vidx_reg;
                end else begin
                    if (age_reg[vidx_reg] < oldest_reg) begin
                        slot_reg   <= vidx_reg;
                        oldest_reg <= age_reg[vidx_reg];
                    end
                    vidx_reg <= vidx_reg + 1'b1;
                end
            end
            S_PLAY_GAIN1: sq_reg <= sep_sq[14:0];
            S_PLAY_GAIN2: begin
                pos_reg[slot_reg]  <= {2'b00, start_reg};
                end_reg[slot_reg]  <= {2'b00, start_reg} + {1'b0, count_reg};
                step_reg[slot_reg] <= STEP_ROM[pitch_reg];
                frac_reg[slot_reg] <= '0;
                age_reg[slot_reg]  <= counter_reg;
                snd_reg[slot_reg]  <= sound_reg;
                gain_reg[slot_reg] <= gain_new;
            end
            S_TICK_SEL: begin
                if (!active_reg[vidx_reg] && !last_voice) vidx_reg <= vidx_reg + 1'b1;
            end
            S_TICK_MUL: begin
                prod_reg           <= smp_c * $signed({1'b0, gain_reg[vidx_reg]});
                frac_reg[vidx_reg] <= frac_sum[15:0];
                pos_reg[vidx_reg]  <= pos_adv;
            end
            S_TICK_ACC: begin
                acc_reg <= acc_reg + ACC_W'(term);
                if (!last_voice) vidx_reg <= vidx_reg + 1'b1;
            end
            S_TICK_OUT: begin
                if (out_free) begin
                    if (acc_reg > ACC_W'(127))
                        m_sample_reg <= 8'd255;
                    else if (acc_reg < -ACC_W'(128))
                        m_sample_reg <= 8'd0;
                    else
                        m_sample_reg <= {~acc_reg[7], acc_reg[6:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_LOAD_WAIT) && mod_done) mem[mod_addr] <= byte_reg;
        if ((state_reg == S_TICK_WAIT) && mod_done) rd_reg <= mem[mod_addr];
    end

    assign m_valid        = m_valid_reg;
    assign m_mixed_sample = m_sample_reg;

    a_counter_only_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_PLAY_GAIN2) |=> $stable(counter_reg))
        else $error("start counter moved outside a voice start");

    a_wrap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> ({1'b0, mod_addr} < (AW+1)'(SAMPLE_MEM_DEPTH)))
        else $error("wrapped address out of range");

    a_out_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK_OUT && out_free) |=> m_valid_reg)
        else $error("tick finished without a result");

    a_gain_start_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLAY_GAIN2) |=> active_reg[$past(slot_reg)])
        else $error("started voice not active");

endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
    import pcmx_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MEM_DEPTH = 262144;
    localparam int NUM_VOICES = 8;
    localparam int NUM_SOUNDS = 128;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic [17:0] mem_addr;
        logic [7:0]  mem_byte;
        logic [7:0]  sound_id;
        logic        exclusive;
        logic [17:0] start_addr;
        logic [18:0] sample_count;
        logic [7:0]  volume;
        logic [7:0]  pitch;
        logic [7:0]  separation;
    } mix_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [17:0] s_mem_addr = '0;
    logic [7:0]  s_mem_byte = '0;
    logic [7:0]  s_sound_id = '0;
    logic        s_exclusive = 1'b0;
    logic [17:0] s_start_addr = '0;
    logic [18:0] s_sample_count = '0;
    logic [7:0]  s_volume = '0;
    logic [7:0]  s_pitch = '0;
    logic [7:0]  s_separation = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_mixed_sample;

    pitched_pcm_voice_mixer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_mem_addr(s_mem_addr), .s_mem_byte(s_mem_byte),
        .s_sound_id(s_sound_id), .s_exclusive(s_exclusive),
        .s_start_addr(s_start_addr), .s_sample_count(s_sample_count),
        .s_volume(s_volume), .s_pitch(s_pitch), .s_separation(s_separation),
        .m_valid(m_valid), .m_ready(m_ready), .m_mixed_sample(m_mixed_sample)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mixer model state
    logic [7:0]  pcm_mem [MEM_DEPTH];
    bit          loaded [MEM_DEPTH];
    int          loaded_addrs [$];
    int          step_tbl [256];
    bit          v_on [NUM_VOICES];
    int          v_pos [NUM_VOICES];
    int          v_end [NUM_VOICES];
    int          v_frac [NUM_VOICES];
    int          v_step [NUM_VOICES];
    int          v_snd [NUM_VOICES];
    int          v_gain [NUM_VOICES];
    logic [31:0] v_age [NUM_VOICES];
    logic [31:0] start_cnt;
    logic [7:0]  mix_expect_q [$];

    int fails = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cnt = 0;

    // exact check of v^64 <= 2^n
    function automatic bit pow64_le(int v, int n);
        logic [1279:0] x;
        x = 1280'(v);
        repeat (6) x = x * x;
        return x <= (1280'(1) << n);
    endfunction

    function automatic int exact_step(int p);
        int est;
        int best;
        est = $rtoi(65536.0 * (2.0 ** ((p - 128) / 64.0)));
        best = 0;
        for (int v = est - 2; v <= est + 2; v++)
            if (v > 0 && pow64_le(v, 896 + p)) best = v;
        return best;
    endfunction

    function void start_voice(mix_item_t it);
        int slot;
        int i;
        int s;
        int g;
        logic [31:0] oldest;
        if (it.sound_id == 0 || it.sound_id >= NUM_SOUNDS) return;
        if (it.exclusive) begin
            for (i = 0; i < NUM_VOICES; i++) begin
                if (v_on[i] && v_snd[i] == int'(it.sound_id)) begin
                    v_on[i] = 1'b0;
                    break;
                end
            end
        end
        oldest = start_cnt;
        slot = 0;
        for (i = 0; i < NUM_VOICES && v_on[i]; i++) begin
            if (v_age[i] < oldest) begin
                slot = i;
                oldest = v_age[i];
            end
        end
        if (i < NUM_VOICES) slot = i;
        v_on[slot] = 1'b1;
        v_pos[slot] = int'(it.start_addr);
        v_end[slot] = int'(it.start_addr) + int'(it.sample_count);
        v_step[slot] = step_tbl[it.pitch];
        v_frac[slot] = 0;
        v_age[slot] = start_cnt;
        start_cnt = start_cnt + 1;
        v_snd[slot] = int'(it.sound_id);
        s = int'(it.separation) - 128;
        g = int'(it.volume) - ((int'(it.volume) * s * s) >> 16);
        if (g < 0) g = 0;
        if (g > 127) g = 127;
        v_gain[slot] = g;
    endfunction

    function logic [7:0] mix_once();
        int acc;
        int smp;
        acc = 0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            if (v_on[i]) begin
                smp = int'(pcm_mem[v_pos[i] % MEM_DEPTH]);
                acc += ((smp - 128) * v_gain[i]) / 127;
                v_frac[i] += v_step[i];
                v_pos[i] += v_frac[i] >> 16;
                v_frac[i] &= 32'hffff;
                if (v_pos[i] >= v_end[i]) v_on[i] = 1'b0;
            end
        end
        if (acc > 127) acc = 127;
        else if (acc < -128) acc = -128;
        return 8'(acc + 128);
    endfunction

    function void apply_item(mix_item_t it);
        case (it.kind)
            KIND_LOAD: begin
                pcm_mem[it.mem_addr] = it.mem_byte;
                if (!loaded[it.mem_addr]) begin
                    loaded[it.mem_addr] = 1'b1;
                    loaded_addrs.push_back(int'(it.mem_addr));
                end
            end
            KIND_PLAY: start_voice(it);
            KIND_TICK: mix_expect_q.push_back(mix_once());
            default: ;
        endcase
    endfunction

    function mix_item_t blank_item(logic [1:0] kind);
        mix_item_t it;
        it.kind = kind;
        it.mem_addr = 18'($urandom);
        it.mem_byte = 8'($urandom);
        it.sound_id = 8'($urandom);
        it.exclusive = 1'($urandom);
        it.start_addr = 18'($urandom);
        it.sample_count = ($urandom_range(0, 3) == 0) ? 19'd262144
                                                      : 19'($urandom_range(1, 262143));
        it.volume = 8'($urandom);
        it.pitch = 8'($urandom);
        it.separation = 8'($urandom);
        return it;
    endfunction

    function mix_item_t load_item(int addr, int data);
        mix_item_t it;
        it = blank_item(KIND_LOAD);
        it.mem_addr = 18'(addr);
        it.mem_byte = 8'(data);
        return it;
    endfunction

    function mix_item_t play_item(int snd, bit excl, int start, int count,
                                  int vol, int pit, int sep);
        mix_item_t it;
        it = blank_item(KIND_PLAY);
        it.sound_id = 8'(snd);
        it.exclusive = excl;
        it.start_addr = 18'(start);
        it.sample_count = 19'(count);
        it.volume = 8'(vol);
        it.pitch = 8'(pit);
        it.separation = 8'(sep);
        return it;
    endfunction

    // number of consecutive loaded addresses from start, wrapping, capped
    function int loaded_run(int start);
        int n;
        n = 0;
        while (n < 200 && loaded[(start + n) % MEM_DEPTH]) n++;
        return n;
    endfunction

    task automatic send_item(mix_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_mem_addr <= it.mem_addr;
        s_mem_byte <= it.mem_byte;
        s_sound_id <= it.sound_id;
        s_exclusive <= it.exclusive;
        s_start_addr <= it.start_addr;
        s_sample_count <= it.sample_count;
        s_volume <= it.volume;
        s_pitch <= it.pitch;
        s_separation <= it.separation;
        do @(posedge aclk); while (!s_ready);
        apply_item(it);
    endtask

    task automatic send_tick();
        send_item(blank_item(KIND_TICK));
    endtask

    // called right after a transfer; valid drops so the item is not taken twice
    task automatic drain_results();
        s_valid <= 1'b0;
        wait (mix_expect_q.size() == 0);
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mix_expect_q.size() == 0) begin
                fails++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output sample %0d", m_mixed_sample);
            end else if (m_mixed_sample !== mix_expect_q[0]) begin
                fails++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mixed_sample mismatch: expected %0d got %0d",
                             mix_expect_q[0], m_mixed_sample);
                void'(mix_expect_q.pop_front());
            end else begin
                void'(mix_expect_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // low window 0..15 and top window wrapping into it
    task automatic test_loads();
        for (int a = 0; a < 16; a++)
            send_item(load_item(a, a < 8 ? 255 : (a < 12 ? 0 : 128 + a)));
        for (int a = MEM_DEPTH - 8; a < MEM_DEPTH; a++)
            send_item(load_item(a, $urandom_range(0, 255)));
    endtask

    // full pool, exclusive release, oldest-voice steal, positive saturation
    task automatic test_voice_alloc();
        for (int v = 1; v <= 8; v++) send_item(play_item(v, 0, 0, 8, 255, 128, 128));
        send_tick();
        send_item(play_item(3, 1, 0, 8, 127, 0, 0));
        send_item(play_item(NUM_SOUNDS - 1, 0, 0, 8, 200, 255, 255));
        send_tick();
        send_tick();
        drain_results();
    endtask

    // negative saturation, zero length, wrap, silent voice
    task automatic test_special_cases();
        for (int v = 0; v < 8; v++) send_item(play_item(10 + v, 1, 8, 4, 255, 128, 128));
        send_tick();
        send_item(play_item(20, 0, 12, 0, 255, 128, 128));
        send_item(play_item(21, 0, MEM_DEPTH - 4, 10, 90, 200, 40));
        send_item(play_item(22, 0, 4, 4, 0, 128, 128));
        send_item(play_item(0, 0, 0, 8, 255, 128, 128));
        send_item(play_item(NUM_SOUNDS, 0, 0, 8, 255, 128, 128));
        send_item(play_item(255, 1, 0, 8, 255, 128, 128));
        send_item(blank_item(KIND_UNUSED));
        repeat (6) send_tick();
        drain_results();
    endtask

    task automatic test_random(int n_items);
        int r;
        int base;
        int a;
        int run;
        mix_item_t it;
        base = $urandom_range(16, MEM_DEPTH - 64);
        for (int k = 0; k < 24; k++) send_item(load_item(base + k, $urandom_range(0, 255)));
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) == 0) drain_results();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_tick();
            end else if (r < 70) begin
                a = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                run = loaded_run(a);
                send_item(play_item($urandom_range(0, 1) ? $urandom_range(1, 6)
                                                         : $urandom_range(1, NUM_SOUNDS - 1),
                                    $urandom_range(0, 1), a, $urandom_range(0, run),
                                    $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255)));
            end else if (r < 85) begin
                send_item(load_item(base + $urandom_range(0, 31), $urandom_range(0, 255)));
            end else if (r < 90) begin
                it = blank_item(KIND_PLAY);
                if ($urandom_range(0, 3) == 0) it.sound_id = 8'd0;
                else it.sound_id = 8'($urandom_range(NUM_SOUNDS, 255));
                send_item(it);
            end else if (r < 94) begin
                send_item(blank_item(KIND_UNUSED));
            end else begin
                send_item(blank_item(KIND_LOAD));
            end
        end
        drain_results();
    endtask

    initial begin
        for (int p = 0; p < 256; p++) step_tbl[p] = exact_step(p);
        for (int i = 0; i < NUM_VOICES; i++) begin
            v_on[i] = 1'b0; v_pos[i] = 0; v_end[i] = 0; v_frac[i] = 0;
            v_step[i] = 0; v_snd[i] = 0; v_gain[i] = 0; v_age[i] = '0;
        end
        start_cnt = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_loads();
        test_voice_alloc();
        test_special_cases();
        send_idle_pct = 13; recv_idle_pct = 74;
        test_random(190);
        send_idle_pct = 74; recv_idle_pct = 13;
        test_random(190);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(190);
        s_valid <= 1'b0;
        wait (mix_expect_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (fails == 0 && mix_expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
